[rtl/lfu_pkg.sv]
package lfu_pkg;

	localparam int unsigned EntriesDefault = 16;
	localparam int unsigned CountBitsDefault = 16;
	localparam int unsigned CapBits = 5;
	localparam logic [CapBits-1:0] CapReset = 5'd16;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	typedef struct packed {
		logic cmd;
		logic signed [31:0] lookup_key;
		logic signed [31:0] write_value;
	} in_word_t;

	typedef struct packed {
		logic found;
		logic signed [31:0] read_value;
		logic evicted;
		logic signed [31:0] evicted_key;
	} out_word_t;

endpackage

[rtl/lfu_ram.sv]
module lfu_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/lfu_ctrl.sv]
module lfu_ctrl #(
	parameter int unsigned ENTRIES = 16,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [lfu_pkg::CapBits-1:0] capacity,
	input  lfu_pkg::in_word_t in_word,
	input  logic              in_valid,
	output logic              in_ready,
	output lfu_pkg::out_word_t out_word,
	output logic              out_valid,
	input  logic              out_ready
);
	import lfu_pkg::*;

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned NB = $clog2(ENTRIES + 1);
	localparam int unsigned RW = 64 + COUNT_BITS + AW;
	localparam logic [COUNT_BITS-1:0] CountMax = '1;
	localparam logic [NB-1:0] LastIdx = NB'(ENTRIES - 1);

	// Each row holds key, value, use count and recency rank.
	typedef struct packed {
		logic [31:0]           key;
		logic [31:0]           value;
		logic [COUNT_BITS-1:0] count;
		logic [AW-1:0]         rank;
	} row_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_SCAN, ST_FIX, ST_WRITE, ST_OUT
	} state_t;

	state_t state_q;
	logic [ENTRIES-1:0] valid_q;
	logic [NB-1:0] occ_q;
	logic [NB-1:0] idx_q;
	logic rd_pend_q;
	logic [AW-1:0] rd_idx_q;
	in_word_t item_q;
	logic hit_q;
	logic [AW-1:0] hit_idx_q;
	row_t hit_row_q;
	logic vic_ok_q;
	logic [AW-1:0] vic_idx_q;
	row_t vic_row_q;
	logic free_ok_q;
	logic [AW-1:0] free_idx_q;
	logic evict_q;
	logic [AW-1:0] tgt_q;
	logic [NB-1:0] cap_q;
	out_word_t out_q;
	logic out_v_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	row_t wrow, rrow;

	lfu_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wrow),
		.raddr(raddr), .rdata(rrow)
	);

	logic [NB-1:0] cap_eff;
	assign cap_eff = (32'(capacity) > ENTRIES) ? NB'(ENTRIES) : NB'(capacity);

	logic row_v;
	assign row_v = valid_q[rd_idx_q];
	assign raddr = idx_q[AW-1:0];
	assign in_ready = (state_q == ST_IDLE) && !out_v_q;
	assign out_word = out_q;
	assign out_valid = out_v_q;

	logic evict_now;
	assign evict_now = !hit_q && (item_q.cmd == CMD_PUT) && (occ_q >= cap_q) && vic_ok_q;

	// Write-back of a row seen in the fix pass, with its rank adjusted where needed.
	row_t fix_row;
	logic fix_we;
	always_comb begin
		fix_row = rrow;
		fix_we = 1'b0;
		if (row_v) begin
			if (hit_q) begin
				if (rd_idx_q != hit_idx_q && rrow.rank < hit_row_q.rank) begin
					fix_row.rank = rrow.rank + 1'b1;
					fix_we = 1'b1;
				end
			end else if (!(evict_q && rd_idx_q == vic_idx_q)) begin
				fix_we = 1'b1;
				if (!(evict_q && rrow.rank > vic_row_q.rank)) begin
					fix_row.rank = rrow.rank + 1'b1;
				end
			end
		end
	end

	row_t new_row;
	always_comb begin
		new_row = hit_row_q;
		if (hit_q) begin
			if (hit_row_q.count != CountMax) begin
				new_row.count = hit_row_q.count + 1'b1;
			end
			new_row.rank = '0;
			if (item_q.cmd == CMD_PUT) begin
				new_row.value = item_q.write_value;
			end
		end else begin
			new_row.key = item_q.lookup_key;
			new_row.value = item_q.write_value;
			new_row.count = COUNT_BITS'(1);
			new_row.rank = '0;
		end
	end

	always_comb begin
		we = 1'b0;
		waddr = rd_idx_q;
		wrow = fix_row;
		if (state_q == ST_CLEAR) begin
			we = 1'b1;
			waddr = idx_q[AW-1:0];
			wrow = '0;
		end else if (state_q == ST_FIX && rd_pend_q) begin
			we = fix_we;
		end else if (state_q == ST_WRITE) begin
			we = 1'b1;
			waddr = tgt_q;
			wrow = new_row;
		end
	end

	logic better;
	assign better = !vic_ok_q || rrow.count < vic_row_q.count ||
		(rrow.count == vic_row_q.count && rrow.rank > vic_row_q.rank);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			valid_q <= '0;
			occ_q <= '0;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (idx_q == LastIdx) begin
						idx_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_word;
						cap_q <= cap_eff;
						hit_q <= 1'b0;
						vic_ok_q <= 1'b0;
						free_ok_q <= 1'b0;
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						if (cap_eff == '0) begin
							out_q <= '{found: 1'b0, read_value: '1, evicted: 1'b0,
								evicted_key: '0};
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_pend_q <= (idx_q <= LastIdx);
					rd_idx_q <= idx_q[AW-1:0];
					if (idx_q <= LastIdx) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rd_pend_q) begin
						if (row_v) begin
							if (!hit_q && rrow.key == item_q.lookup_key) begin
								hit_q <= 1'b1;
								hit_idx_q <= rd_idx_q;
								hit_row_q <= rrow;
							end
							if (better) begin
								vic_ok_q <= 1'b1;
								vic_idx_q <= rd_idx_q;
								vic_row_q <= rrow;
							end
						end else if (!free_ok_q) begin
							free_ok_q <= 1'b1;
							free_idx_q <= rd_idx_q;
						end
					end else if (idx_q > LastIdx) begin
						idx_q <= '0;
						evict_q <= evict_now;
						if (hit_q) begin
							tgt_q <= hit_idx_q;
							out_q <= '{found: 1'b1,
								read_value: (item_q.cmd == CMD_GET) ? hit_row_q.value : '1,
								evicted: 1'b0, evicted_key: '0};
							state_q <= ST_FIX;
						end else if (item_q.cmd == CMD_GET) begin
							out_q <= '{found: 1'b0, read_value: '1, evicted: 1'b0,
								evicted_key: '0};
							state_q <= ST_OUT;
						end else begin
							out_q <= '{found: 1'b0, read_value: '1, evicted: evict_now,
								evicted_key: evict_now ? vic_row_q.key : '0};
							if (evict_now) begin
								tgt_q <= free_ok_q && free_idx_q < vic_idx_q ?
									free_idx_q : vic_idx_q;
								state_q <= ST_FIX;
							end else if (free_ok_q) begin
								tgt_q <= free_idx_q;
								state_q <= ST_FIX;
							end else begin
								state_q <= ST_OUT;
							end
						end
					end
				end
				ST_FIX: begin
					rd_pend_q <= (idx_q <= LastIdx);
					rd_idx_q <= idx_q[AW-1:0];
					if (idx_q <= LastIdx) begin
						idx_q <= idx_q + 1'b1;
					end else if (!rd_pend_q) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					if (!hit_q) begin
						if (!evict_q) begin
							occ_q <= occ_q + 1'b1;
						end else if (vic_idx_q != tgt_q) begin
							valid_q[vic_idx_q] <= 1'b0;
						end
						valid_q[tgt_q] <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[rtl/lfu_cache_lru_tiebreak_top.sv]
// Channel  Direction  Payload / data
// in       input      in_word_t: cmd, lookup_key, write_value
// out      output     out_word_t: found, read_value, evicted, evicted_key
// cfg      input      capacity, 5 bits
// A hit or a put of a new key passes from acceptance to a valid result through
// a scan pass and a rank fix pass over the row memory, then a write-back.
// A get miss ends after the scan pass; any word at capacity zero skips all passes.
// After reset a clearing pass over every row runs before the first word is accepted.
// A stalled result holds the block until it is taken.
module lfu_cache_lru_tiebreak_top #(
	parameter int unsigned ENTRIES = lfu_pkg::EntriesDefault,
	parameter int unsigned COUNT_BITS = lfu_pkg::CountBitsDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lfu_pkg::in_word_t  in_word,
	input  logic               in_valid,
	output logic               in_ready,
	output lfu_pkg::out_word_t out_word,
	output logic               out_valid,
	input  logic               out_ready,
	input  logic [lfu_pkg::CapBits-1:0] cfg_data,
	input  logic               cfg_valid,
	output logic               cfg_ready
);
	import lfu_pkg::*;

	logic [CapBits-1:0] capacity_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CapReset;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	lfu_ctrl #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .capacity(capacity_q),
		.in_word(in_word), .in_valid(in_valid), .in_ready(in_ready),
		.out_word(out_word), .out_valid(out_valid), .out_ready(out_ready)
	);

`ifndef NO_ASSERTIONS
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input accepted with result pending");
	a_put_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.evicted) |-> (out_word.read_value == '1 && !out_word.found))
		else $error("eviction with a hit");
	a_evict_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_word.evicted) |-> out_word.evicted_key == '0)
		else $error("evicted key without eviction");
`endif
endmodule

[verif/lfu_cache_lru_tiebreak_top_tb.sv]
`timescale 1ns / 100ps

module lfu_cache_lru_tiebreak_top_tb;
	import lfu_pkg::*;

	localparam int unsigned ENTRIES = 16;
	localparam int unsigned COUNT_BITS = 16;
	localparam int unsigned RANDOM_WORDS = 1400;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_CYCLES = 2 * ENTRIES + 20;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	class lfu_scoreboard;
		logic [4:0] capacity;
		bit valid_q[ENTRIES];
		logic [31:0] key_q[ENTRIES];
		logic [31:0] value_q[ENTRIES];
		logic [COUNT_BITS-1:0] count_q[ENTRIES];
		int unsigned rank_q[ENTRIES];
		int unsigned occupancy;
		out_word_t pending_results[$];
		int unsigned errors;

		function void clear_store();
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] = 0;
				key_q[i] = '0;
				value_q[i] = '0;
				count_q[i] = '0;
				rank_q[i] = 0;
			end
			occupancy = 0;
			capacity = CapReset;
			errors = 0;
		endfunction

		function void make_recent(int s);
			int unsigned old_rank;
			old_rank = rank_q[s];
			for (int i = 0; i < ENTRIES; i++)
				if (i != s && valid_q[i] && rank_q[i] < old_rank)
					rank_q[i]++;
			rank_q[s] = 0;
		endfunction

		function void raise_use(int s);
			if (count_q[s] != COUNT_MAX)
				count_q[s]++;
			make_recent(s);
		endfunction

		function int lowest_use_slot();
			int v;
			v = -1;
			for (int i = 0; i < ENTRIES; i++) begin
				if (!valid_q[i])
					continue;
				if (v < 0 || count_q[i] < count_q[v] ||
						(count_q[i] == count_q[v] && rank_q[i] > rank_q[v]))
					v = i;
			end
			return v;
		endfunction

		function void note_word(in_word_t w);
			out_word_t r;
			int unsigned cap;
			int s, v;
			int unsigned gone;
			r = '{found: 1'b0, read_value: -32'sd1, evicted: 1'b0, evicted_key: '0};
			cap = (capacity > ENTRIES) ? ENTRIES : capacity;
			if (cap != 0) begin
				s = -1;
				for (int i = 0; i < ENTRIES; i++)
					if (s < 0 && valid_q[i] && key_q[i] == w.lookup_key)
						s = i;
				if (s >= 0) begin
					if (w.cmd == CMD_PUT)
						value_q[s] = w.write_value;
					else
						r.read_value = value_q[s];
					raise_use(s);
					r.found = 1'b1;
				end else if (w.cmd == CMD_PUT) begin
					if (occupancy >= cap) begin
						v = lowest_use_slot();
						if (v >= 0) begin
							r.evicted = 1'b1;
							r.evicted_key = key_q[v];
							gone = rank_q[v];
							valid_q[v] = 0;
							for (int i = 0; i < ENTRIES; i++)
								if (valid_q[i] && rank_q[i] > gone)
									rank_q[i]--;
							key_q[v] = '0;
							value_q[v] = '0;
							count_q[v] = '0;
							rank_q[v] = 0;
							if (occupancy > 0)
								occupancy--;
						end
					end
					s = -1;
					for (int i = 0; i < ENTRIES; i++)
						if (s < 0 && !valid_q[i])
							s = i;
					if (s >= 0) begin
						for (int i = 0; i < ENTRIES; i++)
							if (valid_q[i])
								rank_q[i]++;
						valid_q[s] = 1;
						key_q[s] = w.lookup_key;
						value_q[s] = w.write_value;
						count_q[s] = COUNT_BITS'(1);
						rank_q[s] = 0;
						occupancy++;
					end
				end
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(out_word_t got);
			out_word_t exp;
			if (pending_results.size() == 0) begin
				$error("unexpected result word %h", got);
				errors++;
				return;
			end
			exp = pending_results.pop_front();
			if (got.found !== exp.found) begin
				$error("found: expected %0d, actual %0d", exp.found, got.found);
				errors++;
			end
			if (got.read_value !== exp.read_value) begin
				$error("read_value: expected %0d, actual %0d", exp.read_value, got.read_value);
				errors++;
			end
			if (got.evicted !== exp.evicted) begin
				$error("evicted: expected %0d, actual %0d", exp.evicted, got.evicted);
				errors++;
			end
			if (got.evicted_key !== exp.evicted_key) begin
				$error("evicted_key: expected %0d, actual %0d", exp.evicted_key,
					got.evicted_key);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	in_word_t in_word;
	logic in_valid;
	logic in_ready;
	out_word_t out_word;
	logic out_valid;
	logic out_ready;
	logic [CapBits-1:0] cfg_data;
	logic cfg_valid;
	logic cfg_ready;

	lfu_scoreboard cache_sb;
	bit calm;
	int unsigned cycle_count = 0;
	logic [31:0] key_pool[8];

	lfu_cache_lru_tiebreak_top #(
		.ENTRIES(ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_word(in_word),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.out_word(out_word),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cfg_data(cfg_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cache_sb = new();
		cache_sb.clear_store();
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
		if (arst_n && in_valid && in_ready)
			cache_sb.note_word(in_word);
		if (arst_n && out_valid && out_ready)
			cache_sb.check_result(out_word);
	end

	initial begin
		int unsigned gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 19);
				out_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	task automatic send_word(logic cmd, logic [31:0] k, logic [31:0] v);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_word <= '{cmd: cmd, lookup_key: k, write_value: v};
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_capacity(logic [4:0] c);
		in_valid <= 1'b0;
		while (cache_sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_data <= c;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cache_sb.capacity = c;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int unsigned n, int unsigned pool_size);
		logic [31:0] k;
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				k = $urandom();
			else
				k = key_pool[$urandom_range(0, pool_size - 1)];
			send_word(1'($urandom_range(0, 1)), k, $urandom());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		calm = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		for (int i = 0; i < 8; i++)
			key_pool[i] = $urandom();
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0;
		key_pool[3] = 32'hFFFF_FFFF;

		send_word(CMD_GET, 32'h8000_0000, 32'h0);
		send_word(CMD_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_word(CMD_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_word(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(CMD_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_word(CMD_GET, 32'h7FFF_FFFF, 32'h0);
		send_word(CMD_PUT, 32'hFFFF_FFFF, 32'h0);
		send_word(CMD_PUT, 32'h0, 32'h1234_5678);
		send_word(CMD_GET, 32'h0, 32'h0);

		write_capacity(5'd2);
		send_word(CMD_PUT, 32'h11, 32'h1);
		send_word(CMD_PUT, 32'h22, 32'h2);
		send_word(CMD_GET, 32'h7FFF_FFFF, 32'h0);
		send_word(CMD_PUT, 32'h33, 32'h3);
		send_word(CMD_PUT, 32'h44, 32'h4);

		write_capacity(5'd0);
		send_word(CMD_GET, 32'h44, 32'h0);
		send_word(CMD_PUT, 32'h44, 32'h5);
		send_word(CMD_PUT, 32'h55, 32'h5);

		write_capacity(5'd31);
		send_word(CMD_GET, 32'h44, 32'h0);
		send_word(CMD_PUT, 32'h66, 32'h6);

		write_capacity(5'd1);
		random_phase(300, 3);
		write_capacity(5'd16);
		random_phase(350, 8);
		write_capacity(5'd4);
		random_phase(300, 8);
		write_capacity(5'd0);
		random_phase(50, 8);
		write_capacity(5'd20);
		random_phase(200, 8);
		write_capacity(5'd3);
		calm = 1'b1;
		random_phase(200, 6);

		in_valid <= 1'b0;
		while (cache_sb.pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (cache_sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
